// ----- design/touch_debounce_long_press_macros.svh -----
// Assertion macros used by the touch debounce core (tdlp_core).
`ifndef TOUCH_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define TOUCH_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define TDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define TDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tdlp_pkg.sv -----
// Package with the types, codes and constants of the touch debounce block.
`timescale 1ns / 1ps
package tdlp_pkg;

  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int EV_W   = 2;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EV_W-1:0] EV_PRESSED  = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASED = 2'd2;
  localparam logic [EV_W-1:0] EV_LONG     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_ACTIVE_LOW  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LONG_PRESS  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_LONG_ENABLE = 2'd3;

  // Reset values of the timing registers.
  localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic            active_low;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
    logic            long_press_enable;
  } tdlp_cfg_t;

  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;
    logic              clear_counts;
  } tdlp_smp_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [TIME_W-1:0] duration_ms;
    logic              is_touched;
    logic              long_press_seen;
    logic [TIME_W-1:0] press_total;
    logic [TIME_W-1:0] long_press_total;
  } tdlp_res_t;

endpackage

// ----- design/tdlp_if.sv -----
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps
interface tdlp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      raw_level;
  logic [tdlp_pkg::TIME_W-1:0] now_ms;
  logic                      clear_counts;

  modport source (output valid, output raw_level, output now_ms, output clear_counts,
                  input ready);
  modport sink (input valid, input raw_level, input now_ms, input clear_counts,
                output ready);
endinterface

interface tdlp_out_if;
  logic                        valid;
  logic                        ready;
  logic [tdlp_pkg::EV_W-1:0]   event_res;
  logic [tdlp_pkg::TIME_W-1:0] duration_ms;
  logic                        is_touched;
  logic                        long_press_seen;
  logic [tdlp_pkg::TIME_W-1:0] press_total;
  logic [tdlp_pkg::TIME_W-1:0] long_press_total;

  modport source (output valid, output event_res, output duration_ms, output is_touched,
                  output long_press_seen, output press_total, output long_press_total,
                  input ready);
  modport sink (input valid, input event_res, input duration_ms, input is_touched,
                input long_press_seen, input press_total, input long_press_total,
                output ready);
endinterface

// ----- design/tdlp_cfg_regs.sv -----
// Configuration register file of the touch debounce block.
`timescale 1ns / 1ps
module tdlp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tdlp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tdlp_pkg::CFG_DW-1:0] cfg_wdata,
  output tdlp_pkg::tdlp_cfg_t         cfg
);

  tdlp_pkg::tdlp_cfg_t cfg_r;
  tdlp_pkg::tdlp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        tdlp_pkg::REG_ACTIVE_LOW:  cfg_nxt.active_low        = cfg_wdata[0];
        tdlp_pkg::REG_DEBOUNCE:    cfg_nxt.debounce_ms       = cfg_wdata;
        tdlp_pkg::REG_LONG_PRESS:  cfg_nxt.long_press_ms     = cfg_wdata;
        tdlp_pkg::REG_LONG_ENABLE: cfg_nxt.long_press_enable = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low        <= 1'b0;
      cfg_r.debounce_ms       <= tdlp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms     <= tdlp_pkg::LONG_PRESS_RST;
      cfg_r.long_press_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/tdlp_core.sv -----
// Sample register, debounce state and the per-sample event logic.
`timescale 1ns / 1ps
`include "touch_debounce_long_press_macros.svh"
module tdlp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tdlp_pkg::tdlp_cfg_t cfg,
  tdlp_in_if.sink             in_bus,
  input  logic                res_take,
  output logic                res_vld,
  output tdlp_pkg::tdlp_res_t res
);

  logic                        in_vld_r;
  tdlp_pkg::tdlp_smp_t         smp_r;
  logic                        adv;

  logic                        last_r, last_nxt;
  logic                        stable_r, stable_nxt;
  logic                        long_done_r, long_done_nxt;
  logic [tdlp_pkg::TIME_W-1:0] chg_time_r, chg_time_nxt;
  logic [tdlp_pkg::TIME_W-1:0] press_time_r, press_time_nxt;
  logic [tdlp_pkg::TIME_W-1:0] press_cnt_r, press_cnt_nxt;
  logic [tdlp_pkg::TIME_W-1:0] long_cnt_r, long_cnt_nxt;

  logic                        level;
  logic                        changed;
  logic [tdlp_pkg::TIME_W-1:0] since;
  logic [tdlp_pkg::TIME_W-1:0] held;
  logic [tdlp_pkg::MS_W-1:0]   lp_ms;
  logic                        accept;
  logic                        press_ev;
  logic                        rel_ev;
  logic                        long_ev;
  logic [tdlp_pkg::TIME_W-1:0] press_base;
  logic [tdlp_pkg::TIME_W-1:0] long_base;

  // The sample register empties whenever the result stage takes its beat.
  assign adv          = in_vld_r & res_take;
  assign in_bus.ready = ~in_vld_r | res_take;
  assign res_vld      = in_vld_r;

  always_comb begin
    level   = smp_r.raw_level ^ cfg.active_low;
    changed = level != last_r;
    // A fresh level restarts the timer, so its stable time is zero.
    since   = changed ? '0 : smp_r.now_ms - chg_time_r;
    held    = smp_r.now_ms - press_time_r;
    lp_ms   = (cfg.long_press_ms == '0) ? tdlp_pkg::MS_W'(1) : cfg.long_press_ms;

    accept   = (since >= {{(tdlp_pkg::TIME_W-tdlp_pkg::MS_W){1'b0}}, cfg.debounce_ms})
               && (level != stable_r);
    press_ev = accept & level;
    rel_ev   = accept & ~level;

    stable_nxt = accept ? level : stable_r;
    // A press restarts the hold time at zero, which never reaches the long-press time.
    long_ev    = stable_nxt & cfg.long_press_enable & ~long_done_r & ~press_ev
                 & (held >= {{(tdlp_pkg::TIME_W-tdlp_pkg::MS_W){1'b0}}, lp_ms});

    last_nxt       = level;
    chg_time_nxt   = changed ? smp_r.now_ms : chg_time_r;
    press_time_nxt = press_ev ? smp_r.now_ms : press_time_r;
    long_done_nxt  = press_ev ? 1'b0 : (long_ev ? 1'b1 : long_done_r);

    press_base    = smp_r.clear_counts ? '0 : press_cnt_r;
    long_base     = smp_r.clear_counts ? '0 : long_cnt_r;
    press_cnt_nxt = press_base + {{(tdlp_pkg::TIME_W-1){1'b0}}, press_ev};
    long_cnt_nxt  = long_base + {{(tdlp_pkg::TIME_W-1){1'b0}}, long_ev};

    if (long_ev) begin
      res.event_res = tdlp_pkg::EV_LONG;
    end else if (press_ev) begin
      res.event_res = tdlp_pkg::EV_PRESSED;
    end else if (rel_ev) begin
      res.event_res = tdlp_pkg::EV_RELEASED;
    end else begin
      res.event_res = tdlp_pkg::EV_NONE;
    end
    res.duration_ms      = (long_ev | rel_ev) ? held : '0;
    res.is_touched       = stable_nxt;
    res.long_press_seen  = long_done_nxt;
    res.press_total      = press_cnt_nxt;
    res.long_press_total = long_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      smp_r.raw_level    <= in_bus.raw_level;
      smp_r.now_ms       <= in_bus.now_ms;
      smp_r.clear_counts <= in_bus.clear_counts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r       <= 1'b0;
      stable_r     <= 1'b0;
      long_done_r  <= 1'b0;
      chg_time_r   <= '0;
      press_time_r <= '0;
      press_cnt_r  <= '0;
      long_cnt_r   <= '0;
    end else if (adv) begin
      last_r       <= last_nxt;
      stable_r     <= stable_nxt;
      long_done_r  <= long_done_nxt;
      chg_time_r   <= chg_time_nxt;
      press_time_r <= press_time_nxt;
      press_cnt_r  <= press_cnt_nxt;
      long_cnt_r   <= long_cnt_nxt;
    end
  end

  `TDLP_ASSERT_NEXT(a_long_sets_done, adv && res.event_res == tdlp_pkg::EV_LONG, long_done_r, "long press event did not mark the touch")
  `TDLP_ASSERT_NEXT(a_press_state, adv && res.event_res == tdlp_pkg::EV_PRESSED, stable_r && !long_done_r, "press event left wrong touch state")
  `TDLP_ASSERT_NEXT(a_release_state, adv && res.event_res == tdlp_pkg::EV_RELEASED, !stable_r, "release event left touch state set")
  `TDLP_ASSERT_NEXT(a_hold_counts, !adv, $stable(press_cnt_r) && $stable(long_cnt_r), "counters moved without a sample")
  `TDLP_ASSERT_NOW(a_dur_zero, res.event_res == tdlp_pkg::EV_NONE || res.event_res == tdlp_pkg::EV_PRESSED, res.duration_ms == '0, "duration set without a hold event")

endmodule

// ----- design/tdlp_out_reg.sv -----
// Result register that drives the output channel.
`timescale 1ns / 1ps
module tdlp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_vld,
  input  tdlp_pkg::tdlp_res_t res,
  output logic                res_take,
  tdlp_out_if.source          out_bus
);

  logic                out_vld_r;
  tdlp_pkg::tdlp_res_t res_r;
  logic                load;

  assign res_take = ~out_vld_r | out_bus.ready;
  assign load     = res_vld & res_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid            = out_vld_r;
  assign out_bus.event_res        = res_r.event_res;
  assign out_bus.duration_ms      = res_r.duration_ms;
  assign out_bus.is_touched       = res_r.is_touched;
  assign out_bus.long_press_seen  = res_r.long_press_seen;
  assign out_bus.press_total      = res_r.press_total;
  assign out_bus.long_press_total = res_r.long_press_total;

endmodule

// ----- design/touch_debounce_long_press.sv -----
// Top level of the touch debounce and long-press detector.
`timescale 1ns / 1ps
// Touch debounce with long-press detection. Each beat on the input channel is
// one pin sample together with the current millisecond time and a flag that
// zeroes the press and long-press counters before the sample is handled. The
// level is inverted when active_low is set, any change restarts the debounce
// timer, and a level that has stayed put for debounce_ms becomes the touch
// state. Every sample yields exactly one result beat: a press, a release with
// its hold time, a single long press once the hold reaches long_press_ms (zero
// counts as one) and long_press_enable is set, or no event, always with the
// touch state and both counters. All time differences wrap modulo 2^32. The
// block takes one sample per clock while out_bus.ready lets results drain. An
// accepted sample is held in the sample register, whose compare-and-subtract
// logic updates the debounce state, and then in the result register. The
// result register frees itself in the same cycle its beat is taken, so a
// stalled output holds at most one pending sample upstream. Configuration
// writes through cfg_we, cfg_addr and cfg_wdata are registered before they
// take effect and are meant to be issued while no sample is in flight.
module touch_debounce_long_press (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tdlp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tdlp_pkg::CFG_DW-1:0] cfg_wdata,
  tdlp_in_if.sink                     in_bus,
  tdlp_out_if.source                  out_bus
);

  tdlp_pkg::tdlp_cfg_t cfg;
  tdlp_pkg::tdlp_res_t res;
  logic                res_vld;
  logic                res_take;

  tdlp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sample register plus the debounce state machine.
  tdlp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_bus   (in_bus),
    .res_take (res_take),
    .res_vld  (res_vld),
    .res      (res)
  );

  // Result register that parts the two channels.
  tdlp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take),
    .out_bus  (out_bus)
  );

endmodule
